// ----- src/windowed_amplitude_histogram_assert.svh -----
`ifndef WINDOWED_AMPLITUDE_HISTOGRAM_ASSERT_SVH
`define WINDOWED_AMPLITUDE_HISTOGRAM_ASSERT_SVH

// same-cycle implication on i_clk, off during reset
`define WAH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication on i_clk, off during reset
`define WAH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wah_pkg.sv -----
package wah_pkg;

    localparam int MAX_BINS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 17;

    localparam int WLEN_BITS     = 17;
    localparam int BINS_BITS     = 7;
    localparam int WIN_BITS      = 20;
    localparam int FILL_BITS     = 17;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 17'd1024;
    localparam logic [BINS_BITS-1:0] BINS_RESET = 7'd50;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_BIN_COUNT     = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_READ   = 4'b0100,
        ST_SEND   = 4'b1000
    } t_state;

endpackage

// ----- src/windowed_amplitude_histogram.sv -----
// Windowed amplitude histogram. Each Q1.15 sample is sorted into one of
// bin_count equal-width amplitude bins over [-1, 1] and counted in a bin
// memory with registered reads. For each sample, the bin
// is computed and its count read in the accept cycle, the saturated count
// is written back in the next. When window_length samples have been seen,
// or a sample carries final_req, every bin word is sent out in bin order:
// each bin is read from memory, then sent as one output word that is held
// until it is taken, and no sample is accepted until the last
// word of the window is taken. Bins are all cleared at once by per-bin
// valid flags, so no clearing pass follows reset or readout. The
// configuration port is always ready; write it only while the block is idle.
module windowed_amplitude_histogram #(
    parameter int MAX_BINS    = wah_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS = wah_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = wah_pkg::COUNT_BITS_DEF,
    localparam int IDX_BITS   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_final_req,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [wah_pkg::WIN_BITS-1:0]      o_window_number,
    output logic [IDX_BITS-1:0]               o_bin_index,
    output logic [COUNT_BITS-1:0]             o_bin_count_res,
    output logic                              o_last_of_window,
    output logic                              o_partial,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wah_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [wah_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

`include "windowed_amplitude_histogram_assert.svh"

    localparam int NB_BITS   = $clog2(MAX_BINS + 1);
    localparam int PROD_BITS = SAMPLE_BITS + NB_BITS;

    wah_pkg::t_state r_state, n_state;

    logic [wah_pkg::WLEN_BITS-1:0] r_cfg_wlen;
    logic [wah_pkg::BINS_BITS-1:0] r_cfg_bins;
    logic [wah_pkg::FILL_BITS-1:0] r_fill;
    logic [wah_pkg::WIN_BITS-1:0]  r_win_cnt;
    logic [wah_pkg::WIN_BITS-1:0]  r_out_win;
    logic [MAX_BINS-1:0]           r_vld;
    logic [IDX_BITS-1:0]           r_idx;
    logic [IDX_BITS-1:0]           r_bin;
    logic                          r_fin;
    logic                          r_partial;

    logic [COUNT_BITS-1:0] r_mem [MAX_BINS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  r_rd_vld;

    logic [NB_BITS-1:0]            w_bins;
    logic [NB_BITS-1:0]            w_bmax;
    logic [SAMPLE_BITS-1:0]        w_u;
    logic [PROD_BITS-1:0]          w_prod;
    logic [PROD_BITS-1:0]          w_pm1;
    logic [NB_BITS-1:0]            w_q;
    logic [IDX_BITS-1:0]           w_k;
    logic [IDX_BITS-1:0]           w_rd_addr;
    logic [COUNT_BITS-1:0]         w_cur;
    logic [COUNT_BITS-1:0]         w_inc;
    logic [wah_pkg::FILL_BITS-1:0] w_fill_inc;
    logic [wah_pkg::WLEN_BITS-1:0] w_wlen;
    logic                          w_full;
    logic                          w_last;

    // effective bin count and window length
    always_comb begin
        if (r_cfg_bins == '0) begin
            w_bins = NB_BITS'(1);
        end else if (32'(r_cfg_bins) > MAX_BINS) begin
            w_bins = NB_BITS'(MAX_BINS);
        end else begin
            w_bins = NB_BITS'(r_cfg_bins);
        end
    end

    assign w_bmax = w_bins - NB_BITS'(1);
    assign w_wlen = (r_cfg_wlen == '0) ? wah_pkg::WLEN_BITS'(1) : r_cfg_wlen;

    // bin select: smallest i with u*B <= 2^SAMPLE_BITS*(i+1)
    assign w_u    = {~i_sample[SAMPLE_BITS-1], i_sample[SAMPLE_BITS-2:0]};
    assign w_prod = PROD_BITS'(w_u) * PROD_BITS'(w_bins);
    assign w_pm1  = w_prod - PROD_BITS'(1);
    assign w_q    = w_pm1[PROD_BITS-1:SAMPLE_BITS];

    always_comb begin
        if (w_prod == '0) begin
            w_k = '0;
        end else if (w_q > w_bmax) begin
            w_k = IDX_BITS'(w_bmax);
        end else begin
            w_k = IDX_BITS'(w_q);
        end
    end

    assign w_rd_addr = (r_state == wah_pkg::ST_READ) ? r_idx : w_k;

    // bin memory
    always_ff @(posedge i_clk) begin
        if (r_state == wah_pkg::ST_IDLE || r_state == wah_pkg::ST_READ) begin
            r_rdata  <= r_mem[w_rd_addr];
            r_rd_vld <= r_vld[w_rd_addr];
        end
        if (r_state == wah_pkg::ST_UPDATE) begin
            r_mem[r_bin] <= w_inc;
        end
    end

    assign w_cur      = r_rd_vld ? r_rdata : '0;
    assign w_inc      = (w_cur == '1) ? w_cur : w_cur + COUNT_BITS'(1);
    assign w_fill_inc = (r_fill == '1) ? r_fill : r_fill + wah_pkg::FILL_BITS'(1);
    assign w_full     = 32'(w_fill_inc) >= 32'(w_wlen);
    assign w_last     = NB_BITS'(r_idx) == w_bmax;

    always_comb begin
        n_state = r_state;
        case (r_state)
            wah_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = wah_pkg::ST_UPDATE;
                end
            end
            wah_pkg::ST_UPDATE: begin
                n_state = (w_full || r_fin) ? wah_pkg::ST_READ : wah_pkg::ST_IDLE;
            end
            wah_pkg::ST_READ: begin
                n_state = wah_pkg::ST_SEND;
            end
            wah_pkg::ST_SEND: begin
                if (i_ready) begin
                    n_state = w_last ? wah_pkg::ST_IDLE : wah_pkg::ST_READ;
                end
            end
            default: begin
                n_state = wah_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= wah_pkg::ST_IDLE;
            r_cfg_wlen <= wah_pkg::WLEN_RESET;
            r_cfg_bins <= wah_pkg::BINS_RESET;
            r_fill     <= '0;
            r_win_cnt  <= '0;
            r_vld      <= '0;
            r_idx      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (wah_pkg::t_cfg_idx'(i_cfg_index))
                    wah_pkg::CFG_WINDOW_LENGTH: r_cfg_wlen <= i_cfg_data[wah_pkg::WLEN_BITS-1:0];
                    wah_pkg::CFG_BIN_COUNT:     r_cfg_bins <= i_cfg_data[wah_pkg::BINS_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == wah_pkg::ST_UPDATE) begin
                r_vld[r_bin] <= 1'b1;
                if (w_full || r_fin) begin
                    r_fill    <= '0;
                    r_win_cnt <= r_fin ? '0 : r_win_cnt + wah_pkg::WIN_BITS'(1);
                    r_idx     <= '0;
                end else begin
                    r_fill <= w_fill_inc;
                end
            end
            if (r_state == wah_pkg::ST_SEND && i_ready) begin
                if (w_last) begin
                    r_vld <= '0;
                end else begin
                    r_idx <= r_idx + IDX_BITS'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == wah_pkg::ST_IDLE) begin
            r_bin <= w_k;
            r_fin <= i_final_req;
        end
        if (r_state == wah_pkg::ST_UPDATE) begin
            r_out_win <= r_win_cnt;
            r_partial <= !w_full;
        end
    end

    assign o_ready          = (r_state == wah_pkg::ST_IDLE);
    assign o_valid          = (r_state == wah_pkg::ST_SEND);
    assign o_cfg_ready      = 1'b1;
    assign o_window_number  = r_out_win;
    assign o_bin_index      = r_idx;
    assign o_bin_count_res  = w_cur;
    assign o_last_of_window = w_last;
    assign o_partial        = r_partial;

    `WAH_ASSERT_NEXT(a_accept_update, i_valid && o_ready, r_state == wah_pkg::ST_UPDATE,
        "accepted word not followed by bin update")
    `WAH_ASSERT_NEXT(a_clear_after_last, o_valid && i_ready && o_last_of_window, r_vld == '0,
        "bins not cleared after last word of window")
    `WAH_ASSERT_NOW(a_fill_zero_readout, o_valid, r_fill == '0,
        "fill count not cleared during readout")
    `WAH_ASSERT_NOW(a_index_in_range, o_valid, NB_BITS'(r_idx) <= w_bmax,
        "bin index beyond bin count")

endmodule
